// ===== rtl/kmdg_pkg.sv =====
// Shared types and constants for the key matrix debounce and ghost filter.
// No dependencies; imported by the top level.
package kmdg_pkg;

   // Width of one per-key disagreement count
   localparam int unsigned CNT_W = 4;

   // Most key changes recorded from one scan, and the width that counts them
   localparam int unsigned MAX_CHANGES = 16;
   localparam int unsigned CHG_W       = 5;

   // Reset value of the stable_scans register
   localparam logic [CNT_W-1:0] STABLE_SCANS_RESET = 4'd3;

   // Result kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_CHANGE = 2'd1;
   localparam logic [1:0] KIND_GHOST  = 2'd2;

   // Scan sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_CHECK,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/kmdg_ghost_check.sv =====
// Ghost rectangle detector over a tentative key map.
// Standalone combinational logic; used by key_matrix_debounce_ghost_filter.
module kmdg_ghost_check #(
   parameter int unsigned ROWS = 4,
   parameter int unsigned COLS = 4
) (
   input  logic [ROWS*COLS-1:0] key_map,
   output logic                 ghost
);

   // A rectangle on rows a, b has exactly three corners pressed when one of
   // its columns has both rows pressed and the other has only one of them.
   // So a row pair is ghosted when some column has both keys and some other
   // column has exactly one.
   always_comb begin
      logic [COLS-1:0] row_a;
      logic [COLS-1:0] row_b;
      ghost = 1'b0;
      for (int r1 = 0; r1 < ROWS; r1++) begin
         for (int r2 = 0; r2 < ROWS; r2++) begin
            row_a = key_map[r1*COLS +: COLS];
            row_b = key_map[r2*COLS +: COLS];
            if (r2 > r1) begin
               if ((|(row_a & row_b)) && (|(row_a ^ row_b))) begin
                  ghost = 1'b1;
               end
            end
         end
      end
   end

endmodule

// ===== rtl/key_matrix_debounce_ghost_filter.sv =====
// Key matrix debounce with ghost filter, top level.
// Depends on kmdg_pkg and kmdg_ghost_check.
//
// One beat on req_ carries a full scan of raw key levels (bit row*COLS+col,
// 1 pressed). The per-key disagreement counts live in a single-port-write
// count memory read one key per cycle, so a scan passes through accept, a
// sweep over the counts, the ghost check and then, if the batch is kept, a
// walk over the change mask that issues one rsp_ beat per changed key; the
// walk waits while rsp_stall holds a result. A scan with no change or a
// ghosted batch gives a single beat after the check. req_stall stays high
// until the last beat of a scan has been placed in the output register. The
// count memory needs no clearing pass: a valid bit per key, cleared by reset,
// makes an unwritten count read as zero. stable_scans is to be written
// through csr_ only while the block is idle; the block itself does not
// enforce this.
module key_matrix_debounce_ghost_filter #(
   parameter int unsigned ROWS = 4,
   parameter int unsigned COLS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   // scan input
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [15:0]             req_raw_map,
   // results
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic [1:0]              rsp_key_row,
   output logic [1:0]              rsp_key_col,
   output logic                    rsp_now_pressed,
   output logic [4:0]              rsp_dropped_count,
   output logic [15:0]             rsp_key_map,
   output logic                    rsp_last,
   // configuration
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [3:0]              csr_stable_scans
);

   import kmdg_pkg::*;

   localparam int unsigned KEYS  = ROWS * COLS;
   localparam int unsigned IW    = $clog2(KEYS);
   localparam int unsigned RW    = $clog2(ROWS);
   localparam int unsigned CW    = $clog2(COLS);
   localparam logic [IW-1:0] LAST_KEY = IW'(KEYS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

   // Control and scan registers
   state_type        state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [KEYS-1:0]  raw_ff, raw_in;
   logic [KEYS-1:0]  stable_ff, stable_in;
   logic [KEYS-1:0]  change_ff, change_in;
   logic [CHG_W-1:0] chg_cnt_ff, chg_cnt_in;
   logic [CHG_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] stable_scans_ff;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [1:0]       key_row_ff, key_row_in;
   logic [1:0]       key_col_ff, key_col_in;
   logic             pressed_ff, pressed_in;
   logic [4:0]       dropped_ff, dropped_in;
   logic [15:0]      key_map_ff, key_map_in;
   logic             last_ff, last_in;

   // Count memory and its per-entry valid bits
   logic [CNT_W-1:0] cnt_mem [KEYS];
   logic [KEYS-1:0]  cnt_valid_ff;
   logic [CNT_W-1:0] rd_data_ff;
   logic             rd_valid_ff;
   logic [IW-1:0]    rd_addr;
   logic             wr_en;
   logic [CNT_W-1:0] wr_data;

   logic             accept;
   logic             out_free;
   logic             ghost;
   logic [KEYS-1:0]  tentative;
   logic [CNT_W-1:0] cur_cnt;
   logic [CNT_W-1:0] cnt_inc;
   logic             level_differs;
   logic             candidate;
   logic             emit_now;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign tentative = stable_ff ^ change_ff;

   // Count of the key under the sweep, zero until first written
   assign cur_cnt       = rd_valid_ff ? rd_data_ff : '0;
   assign cnt_inc       = cur_cnt + 4'd1;
   assign level_differs = raw_ff[idx_ff] != stable_ff[idx_ff];
   assign candidate     = level_differs && (cnt_inc >= stable_scans_ff);
   assign emit_now      = change_ff[idx_ff] && out_free;

   kmdg_ghost_check #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_ghost (
      .key_map (tentative),
      .ghost   (ghost)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (idx_ff == LAST_KEY) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (chg_cnt_ff != '0 && !ghost) begin
               state_in = ST_EMIT;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_now && left_ff == CHG_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result register
   always_comb begin
      idx_in       = idx_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      raw_in       = raw_ff;
      stable_in    = stable_ff;
      change_in    = change_ff;
      chg_cnt_in   = chg_cnt_ff;
      left_in      = left_ff;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_data      = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      key_row_in   = key_row_ff;
      key_col_in   = key_col_ff;
      pressed_in   = pressed_ff;
      dropped_in   = dropped_ff;
      key_map_in   = key_map_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // take the scan and start reading the first count
            if (accept) begin
               raw_in     = KEYS'(req_raw_map);
               idx_in     = '0;
               change_in  = '0;
               chg_cnt_in = '0;
            end
         end
         ST_SWEEP: begin
            // update one key's count, read the next one
            rd_addr = (idx_ff == LAST_KEY) ? '0 : IW'(idx_ff + 1'b1);
            wr_en   = 1'b1;
            if (!level_differs || candidate) begin
               wr_data = '0;
            end else begin
               wr_data = cnt_inc;
            end
            if (candidate && chg_cnt_ff < CHG_W'(MAX_CHANGES)) begin
               change_in[idx_ff] = 1'b1;
               chg_cnt_in        = chg_cnt_ff + 1'b1;
            end
            idx_in = (idx_ff == LAST_KEY) ? '0 : IW'(idx_ff + 1'b1);
         end
         ST_CHECK: begin
            idx_in  = '0;
            row_in  = '0;
            col_in  = '0;
            left_in = chg_cnt_ff;
            if (chg_cnt_ff != '0 && !ghost) begin
               stable_in = tentative;
            end else if (out_free) begin
               // single beat: no change, or the whole batch dropped
               rsp_valid_in = 1'b1;
               kind_in      = (chg_cnt_ff == '0) ? KIND_NONE : KIND_GHOST;
               key_row_in   = '0;
               key_col_in   = '0;
               pressed_in   = 1'b0;
               dropped_in   = (chg_cnt_ff == '0) ? '0 : chg_cnt_ff;
               key_map_in   = 16'(stable_ff);
               last_in      = 1'b1;
            end
         end
         ST_EMIT: begin
            // walk the change mask in row-major order
            if (emit_now) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_CHANGE;
               key_row_in   = 2'(row_ff);
               key_col_in   = 2'(col_ff);
               pressed_in   = stable_ff[idx_ff];
               dropped_in   = '0;
               key_map_in   = 16'(stable_ff);
               last_in      = (left_ff == CHG_W'(1));
               left_in      = left_ff - 1'b1;
            end
            if (!change_ff[idx_ff] || emit_now) begin
               idx_in = (idx_ff == LAST_KEY) ? '0 : IW'(idx_ff + 1'b1);
               if (col_ff == LAST_COL) begin
                  col_in = '0;
                  row_in = (row_ff == LAST_ROW) ? '0 : RW'(row_ff + 1'b1);
               end else begin
                  col_in = CW'(col_ff + 1'b1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         stable_ff       <= '0;
         cnt_valid_ff    <= '0;
         stable_scans_ff <= STABLE_SCANS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stable_ff    <= stable_in;
         if (wr_en) begin
            cnt_valid_ff[idx_ff] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            stable_scans_ff <= csr_stable_scans;
         end
      end
   end

   // Scan and result payload
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      raw_ff     <= raw_in;
      change_ff  <= change_in;
      chg_cnt_ff <= chg_cnt_in;
      left_ff    <= left_in;
      kind_ff    <= kind_in;
      key_row_ff <= key_row_in;
      key_col_ff <= key_col_in;
      pressed_ff <= pressed_in;
      dropped_ff <= dropped_in;
      key_map_ff <= key_map_in;
      last_ff    <= last_in;
   end

   // Count memory: one write and one registered read a cycle; the sweep
   // reads key k+1 while writing key k, so the two never meet
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[idx_ff] <= wr_data;
      end
      rd_data_ff  <= cnt_mem[rd_addr];
      rd_valid_ff <= cnt_valid_ff[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_key_row       = key_row_ff;
   assign rsp_key_col       = key_col_ff;
   assign rsp_now_pressed   = pressed_ff;
   assign rsp_dropped_count = dropped_ff;
   assign rsp_key_map       = key_map_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for key_matrix_debounce_ghost_filter: drives scans and predicts
// every result beat, including debounce, ghost suppression and changes of stable_scans.
// Depends on kmdg_pkg and the RTL top level only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kmdg_pkg::*;

   localparam int NCOLS     = 4;
   localparam int NKEYS     = 16;
   localparam int MAX_SHOWN = 40;
   localparam int CYCLE_CAP = 1_200_000;

   // one expected result beat
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  row;
      logic [1:0]  col;
      logic        pressed;
      logic [4:0]  dropped;
      logic [15:0] map;
      logic        last;
   } key_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_raw_map = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_key_row;
   logic [1:0]  rsp_key_col;
   logic        rsp_now_pressed;
   logic [4:0]  rsp_dropped_count;
   logic [15:0] rsp_key_map;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_stable_scans = '0;

   key_matrix_debounce_ghost_filter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_map       (req_raw_map),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_key_row       (rsp_key_row),
      .rsp_key_col       (rsp_key_col),
      .rsp_now_pressed   (rsp_now_pressed),
      .rsp_dropped_count (rsp_dropped_count),
      .rsp_key_map       (rsp_key_map),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_stable_scans  (csr_stable_scans)
   );

   // debounce state as the block should hold it
   logic [15:0] db_map = '0;
   logic [3:0]  disagree_cnt [NKEYS];
   logic [3:0]  scans_setting = STABLE_SCANS_RESET;

   key_event_type expected_events [$];
   key_event_type want;

   int gap_pct = 0;
   int hold_pct = 0;
   int mismatches = 0;
   int scans_sent = 0;
   int beats_seen = 0;
   int ghosts_seen = 0;
   int changes_seen = 0;
   int cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < NKEYS; k++) disagree_cnt[k] = '0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                  expected_events.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < hold_pct);
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_SHOWN) $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // three pressed corners of any row/column rectangle means a phantom key
   function automatic logic has_phantom_key(input logic [15:0] m);
      int n;
      for (int r1 = 0; r1 < 4; r1++)
         for (int r2 = r1 + 1; r2 < 4; r2++)
            for (int c1 = 0; c1 < NCOLS; c1++)
               for (int c2 = c1 + 1; c2 < NCOLS; c2++) begin
                  n = m[r1*NCOLS+c1] + m[r1*NCOLS+c2] + m[r2*NCOLS+c1] + m[r2*NCOLS+c2];
                  if (n == 3) return 1'b1;
               end
      return 1'b0;
   endfunction

   // advance the debounce state by one scan and queue the beats it causes
   task automatic debounce_scan(input logic [15:0] raw);
      logic [15:0]   cand;
      logic [15:0]   trial;
      key_event_type ev;
      int            n;
      int            left;
      cand = '0;
      for (int k = 0; k < NKEYS; k++) begin
         if (raw[k] == db_map[k]) begin
            disagree_cnt[k] = '0;
         end else begin
            disagree_cnt[k] = disagree_cnt[k] + 4'd1;
            if (disagree_cnt[k] >= scans_setting) begin
               cand[k] = 1'b1;
               disagree_cnt[k] = '0;
            end
         end
      end
      n = $countones(cand);
      trial = db_map ^ cand;
      ev = '0;
      ev.map = db_map;
      ev.last = 1'b1;
      if (n == 0) begin
         ev.kind = KIND_NONE;
         expected_events.push_back(ev);
      end else if (has_phantom_key(trial)) begin
         ev.kind = KIND_GHOST;
         ev.dropped = n[4:0];
         expected_events.push_back(ev);
      end else begin
         db_map = trial;
         left = n;
         for (int k = 0; k < NKEYS; k++) begin
            if (cand[k]) begin
               left--;
               ev.kind    = KIND_CHANGE;
               ev.row     = 2'(k / NCOLS);
               ev.col     = 2'(k % NCOLS);
               ev.pressed = raw[k];
               ev.map     = trial;
               ev.last    = (left == 0);
               expected_events.push_back(ev);
            end
         end
      end
   endtask

   // result checker: every accepted beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         beats_seen++;
         if (rsp_kind == KIND_GHOST) ghosts_seen++;
         if (rsp_kind == KIND_CHANGE) changes_seen++;
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d map %h", rsp_kind, rsp_key_map));
         end else begin
            want = expected_events.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_key_row !== want.row)
               report_mismatch($sformatf("key_row %0d, want %0d", rsp_key_row, want.row));
            if (rsp_key_col !== want.col)
               report_mismatch($sformatf("key_col %0d, want %0d", rsp_key_col, want.col));
            if (rsp_now_pressed !== want.pressed)
               report_mismatch($sformatf("now_pressed %b, want %b", rsp_now_pressed,
                                         want.pressed));
            if (rsp_dropped_count !== want.dropped)
               report_mismatch($sformatf("dropped_count %0d, want %0d", rsp_dropped_count,
                                         want.dropped));
            if (rsp_key_map !== want.map)
               report_mismatch($sformatf("key_map %h, want %h", rsp_key_map, want.map));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
         end
      end
   end

   // one scan beat; valid stays high after acceptance until the next call changes it
   task automatic send_scan(input logic [15:0] m);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_raw_map <= m;
      do @(posedge clock); while (req_stall !== 1'b0);
      debounce_scan(m);
      scans_sent++;
   endtask

   // hold off the sender until every queued beat has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_events.size() != 0);
   endtask

   task automatic write_stable_scans(input logic [3:0] v);
      drain_results();
      csr_valid        <= 1'b1;
      csr_stable_scans <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid     <= 1'b0;
      scans_setting = v;
   endtask

   // reset value of 3, with a bounce that restarts the count
   task automatic test_default_setting();
      send_scan(16'h0001);
      send_scan(16'h0000);
      repeat (3) send_scan(16'h0001);
   endtask

   // whole matrix at once: fifteen presses, sixteen releases
   task automatic test_all_keys();
      write_stable_scans(4'd1);
      send_scan(16'hFFFF);
      send_scan(16'h0000);
   endtask

   // three corners of a rectangle, pressing and releasing
   task automatic test_ghost_rectangles();
      send_scan(16'h0013);
      send_scan(16'h0033);
      send_scan(16'h0031);
      send_scan(16'h0000);
   endtask

   // a setting of zero accepts at once
   task automatic test_immediate_accept();
      write_stable_scans(4'd0);
      send_scan(16'h8000);
      send_scan(16'h0000);
   endtask

   // largest setting: the count runs right up to fifteen
   task automatic test_slowest_setting();
      write_stable_scans(4'd15);
      repeat (15) send_scan(16'h8421);
   endtask

   // mostly debounced changes held long enough, with bounce, short holds and noise
   task automatic random_scans(input int n_scans);
      int          sent;
      int          pick;
      int          hold;
      int          eff;
      logic [15:0] goal;
      logic [15:0] pat;
      logic [3:0]  rsel;
      logic [3:0]  csel;
      sent = 0;
      while (sent < n_scans) begin
         goal = db_map;
         pick = $urandom_range(99);
         if (pick < 40) begin
            goal[$urandom_range(15)] ^= 1'b1;
         end else if (pick < 55) begin
            goal[$urandom_range(15)] ^= 1'b1;
            goal[$urandom_range(15)] ^= 1'b1;
         end else if (pick < 70) begin
            // row set by column set never ghosts
            rsel = 4'($urandom);
            csel = 4'($urandom);
            goal = '0;
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < NCOLS; c++)
                  if (rsel[r] && csel[c]) goal[r*NCOLS+c] = 1'b1;
         end else if (pick < 85) begin
            goal = 16'($urandom);
         end else begin
            send_scan(16'($urandom));
            sent++;
            continue;
         end
         eff  = (scans_setting == 0) ? 1 : scans_setting;
         hold = eff + $urandom_range(0, 2);
         if ($urandom_range(99) < 15) hold = eff - 1;
         repeat (hold) begin
            pat = goal;
            if ($urandom_range(99) < 10) pat[$urandom_range(15)] ^= 1'b1;
            send_scan(pat);
            sent++;
         end
      end
   endtask

   task automatic test_random_debounce();
      gap_pct  = 25;
      hold_pct = 84;
      write_stable_scans(4'd2);
      random_scans(80);
      write_stable_scans(4'd1);
      random_scans(80);
      gap_pct  = 84;
      hold_pct = 25;
      write_stable_scans(4'd3);
      random_scans(80);
      write_stable_scans(4'd4);
      random_scans(80);
      gap_pct  = 0;
      hold_pct = 0;
      write_stable_scans(4'd0);
      random_scans(80);
      write_stable_scans(4'd1);
      random_scans(40);
      drain_results();
      random_scans(40);
   endtask

   initial begin
      gap_pct  = 25;
      hold_pct = 84;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_setting();
      test_all_keys();
      test_ghost_rectangles();
      test_immediate_accept();
      test_slowest_setting();
      test_random_debounce();

      // let the last beats out, then allow for the block's own latency
      drain_results();
      repeat (40) @(posedge clock);

      $display("Ran %0d scans over stable_scans 0 to 15: %0d result beats checked,",
               scans_sent, beats_seen);
      $display("%0d key changes and %0d ghost-suppressed batches among them.",
               changes_seen, ghosts_seen);
      if (mismatches == 0 && expected_events.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/kmdg_pkg.sv
rtl/kmdg_ghost_check.sv
rtl/key_matrix_debounce_ghost_filter.sv
tb/sv/tb.sv
